// ----- sv/button_press_hold_detector_top_assert.svh -----
// Assertion macros for the button press/hold detector.
// Used by button_press_hold_detector_top; no other dependencies.
`ifndef BUTTON_PRESS_HOLD_DETECTOR_TOP_ASSERT_SVH
`define BUTTON_PRESS_HOLD_DETECTOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, off while reset is asserted
`define BPHD_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds during reset
`define BPHD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPHD_ASSERT(label, clk, rstn, prop, msg)
`define BPHD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- sv/bphd_pkg.sv -----
// Shared types and constants of the button press/hold detector.
// No dependencies; imported by every module of the block.
package bphd_pkg;

  // Field widths
  localparam int CH_W   = 2;
  localparam int NOW_W  = 32;
  localparam int HOLD_W = 16;
  localparam int MASK_W = 4;

  // Configuration register map
  localparam int NUM_HOLD_REGS = 4;
  localparam int HOLD_IDX_W    = $clog2(NUM_HOLD_REGS);
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_IDLE_MASK = 3'd4;

  // Reset values and timing
  localparam logic [HOLD_W-1:0] HOLD_RESET      = 16'd1000;
  localparam logic [MASK_W-1:0] IDLE_MASK_RESET = 4'h0;
  localparam logic [NOW_W-1:0]  DEBOUNCE_MS     = 32'd5;

  // Default channel count
  localparam int CHANNELS_DEF = 4;

  // Stream widths (payload padded to whole bytes)
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 8;

  typedef enum logic [1:0] {
    KIND_PRESS        = 2'd0,
    KIND_RELEASE      = 2'd1,
    KIND_HOLD_RELEASE = 2'd2,
    KIND_HELD         = 2'd3
  } event_kind_e;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic             level;
    logic [NOW_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [NUM_HOLD_REGS-1:0][HOLD_W-1:0] hold_ms;
    logic [MASK_W-1:0]                    idle_mask;
  } cfg_t;

  typedef struct packed {
    logic        emit;
    event_kind_e kind;
  } evt_t;

endpackage

// ----- sv/bphd_cfg_regs.sv -----
// Configuration registers: per-channel hold times and the idle level mask.
// Depends on bphd_pkg.
module bphd_cfg_regs
  import bphd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  // Writes to an index outside the map are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_HOLD_REGS; i++) begin
        cfg_q.hold_ms[i] <= HOLD_RESET;
      end
      cfg_q.idle_mask <= IDLE_MASK_RESET;
    end else if (cfg_we_i) begin
      if (cfg_addr_i < CFG_ADDR_W'(NUM_HOLD_REGS)) begin
        cfg_q.hold_ms[cfg_addr_i[HOLD_IDX_W-1:0]] <= cfg_wdata_i[HOLD_W-1:0];
      end else if (cfg_addr_i == REG_IDLE_MASK) begin
        cfg_q.idle_mask <= cfg_wdata_i[MASK_W-1:0];
      end
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/bphd_chan_state.sv -----
// Per-channel debounce/hold state and the event decision for one item.
// Depends on bphd_pkg.
module bphd_chan_state
  import bphd_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  fire_i,   // item in the input register is consumed this cycle
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output evt_t  evt_o
);

  logic [CHANNELS-1:0]            last_level_q;
  logic [CHANNELS-1:0][NOW_W-1:0] change_time_q;
  logic [CHANNELS-1:0]            held_q;

  logic             present;
  logic             cur_last;
  logic [NOW_W-1:0] cur_time;
  logic             cur_held;
  logic             idle;
  logic             active;
  logic [NOW_W-1:0] elapsed;
  logic             accept_chg;
  logic             set_held;

  // Channels beyond the configured count are ignored
  assign present = {1'b0, item_i.channel} < (CH_W + 1)'(CHANNELS);

  // Select the state of the addressed channel
  always_comb begin
    cur_last = 1'b0;
    cur_time = '0;
    cur_held = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (item_i.channel == CH_W'(c)) begin
        cur_last = last_level_q[c];
        cur_time = change_time_q[c];
        cur_held = held_q[c];
      end
    end
  end

  // Debounce and hold decision
  assign idle       = cfg_i.idle_mask[item_i.channel];
  assign active     = item_i.level != idle;
  assign elapsed    = item_i.now_ms - cur_time;   // wraps modulo 2^32
  assign accept_chg = (item_i.level != cur_last) && (elapsed > DEBOUNCE_MS);
  assign set_held   = !accept_chg && !cur_held &&
                      (elapsed > {{(NOW_W-HOLD_W){1'b0}}, cfg_i.hold_ms[item_i.channel]});

  always_comb begin
    evt_o.emit = present && (accept_chg || (set_held && active));
    if (!accept_chg) begin
      evt_o.kind = KIND_HELD;
    end else if (active) begin
      evt_o.kind = KIND_PRESS;
    end else if (cur_held) begin
      evt_o.kind = KIND_HOLD_RELEASE;
    end else begin
      evt_o.kind = KIND_RELEASE;
    end
  end

  // State update of the addressed channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        last_level_q[c]  <= IDLE_MASK_RESET[c];
        change_time_q[c] <= '0;
        held_q[c]        <= 1'b0;
      end
    end else if (fire_i && present) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (item_i.channel == CH_W'(c)) begin
          last_level_q[c] <= item_i.level;
          if (accept_chg) begin
            held_q[c]        <= 1'b0;
            change_time_q[c] <= item_i.now_ms;
          end else if (set_held) begin
            held_q[c] <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// ----- sv/button_press_hold_detector_top.sv -----
// Button press/hold detector: top level with input and result registers.
// Depends on bphd_pkg, bphd_cfg_regs, bphd_chan_state and the assert header.
//
// Usage: each item on the s_axis channel is one sample of one button channel
// (channel, pin level, millisecond time stamp). The block answers with zero or
// one event item on m_axis: press, release, hold release or held, tagged with
// the channel. Samples of channels at or above CHANNELS are dropped.
// Hold times and the idle level mask are set through the cfg write port while
// no item is in flight; a write takes effect at the next edge.
// An event appears on m_axis once its sample has passed the input register and then the result register.
// Throughput: one sample per cycle unless m_axis stalls; the addressed channel's
// state is read and written back in the same cycle, so samples of one channel
// may follow directly. Samples that cause no event leave nothing on the output.
// Reset clears all channel state (level low, change time zero, held clear) and
// returns the registers to 1000 ms hold time and idle mask zero.
// When the receiver stalls, the pending event is held on m_axis; one more
// sample is kept in the input register and s_axis_tready then drops.
module button_press_hold_detector_top
  import bphd_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Sample stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // channel[1:0], level[2], now_ms[34:3]
  // Event stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,   // event_channel[1:0], event_kind[3:2]
  // Configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  `include "button_press_hold_detector_top_assert.svh"

  logic        in_valid_q;
  logic        in_valid_d;
  item_t       in_item_q;
  logic        out_valid_q;
  logic        out_valid_d;
  logic [CH_W-1:0] out_chan_q;
  event_kind_e out_kind_q;
  logic        out_free;
  logic        fire;
  logic        s_accept;
  cfg_t        cfg;
  evt_t        evt;

  bphd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bphd_chan_state #(
    .CHANNELS (CHANNELS)
  ) u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .evt_o  (evt)
  );

  // Handshake: an item moves on when the result register is free or draining
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = fire && evt.emit;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q.channel <= s_axis_tdata[CH_W-1:0];
      in_item_q.level   <= s_axis_tdata[CH_W];
      in_item_q.now_ms  <= s_axis_tdata[CH_W+NOW_W:CH_W+1];
    end
    if (fire && evt.emit && out_free) begin
      out_chan_q <= in_item_q.channel;
      out_kind_q <= evt.kind;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W-2*CH_W){1'b0}}, out_kind_q, out_chan_q};

  // Checks
  `BPHD_ASSERT(a_evt_chan_present, clk_i, rst_ni,
               out_valid_q |-> ({1'b0, out_chan_q} < (CH_W + 1)'(CHANNELS)),
               "event for an absent channel")
  `BPHD_ASSERT(a_stalled_item_kept, clk_i, rst_ni,
               (in_valid_q && !out_free) |=> (in_valid_q && $stable(in_item_q)),
               "stalled item lost")
  `BPHD_ASSERT(a_ready_only_when_room, clk_i, rst_ni,
               !s_axis_tready |-> (in_valid_q && out_valid_q), "ready low with room")
  // Registers are cleared by the edge after reset is seen
  `BPHD_ASSERT_ALWAYS(a_reset_clears, clk_i,
                      !rst_ni |=> (!in_valid_q && !out_valid_q), "valid set in reset")

endmodule
